FILE: rtl/core/rvdec_pkg.sv
// Package for the RV32I subset decoder: opcode, funct3 and funct7 codes,
// operation and format enumerations.
// No dependencies; used by the interfaces, the decoder and its checker.
`default_nettype none

package rvdec_pkg;

   // Major opcodes, bits 6..0
   localparam logic [6:0] OPC_REG    = 7'b0110011;
   localparam logic [6:0] OPC_IMM    = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;

   // funct7, bits 31..25
   localparam logic [6:0] F7_ZERO = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   // funct3, bits 14..12, ALU group
   localparam logic [2:0] F3_ADD = 3'b000;
   localparam logic [2:0] F3_SLL = 3'b001;
   localparam logic [2:0] F3_SLT = 3'b010;
   localparam logic [2:0] F3_XOR = 3'b100;
   localparam logic [2:0] F3_SR  = 3'b101;
   localparam logic [2:0] F3_OR  = 3'b110;
   localparam logic [2:0] F3_AND = 3'b111;
   // funct3, memory and branch groups
   localparam logic [2:0] F3_WORD = 3'b010;
   localparam logic [2:0] F3_BEQ  = 3'b000;
   localparam logic [2:0] F3_BNE  = 3'b001;
   localparam logic [2:0] F3_BLT  = 3'b100;
   localparam logic [2:0] F3_BGE  = 3'b101;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned OP_W   = 5;
   localparam int unsigned FMT_W  = 3;
   localparam int unsigned REG_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 5'd0,
      OP_SUB   = 5'd1,
      OP_XOR   = 5'd2,
      OP_OR    = 5'd3,
      OP_AND   = 5'd4,
      OP_SLL   = 5'd5,
      OP_SLT   = 5'd6,
      OP_SRL   = 5'd7,
      OP_SRA   = 5'd8,
      OP_SLTI  = 5'd9,
      OP_ADDI  = 5'd10,
      OP_ANDI  = 5'd11,
      OP_XORI  = 5'd12,
      OP_ORI   = 5'd13,
      OP_SLLI  = 5'd14,
      OP_SRLI  = 5'd15,
      OP_SRAI  = 5'd16,
      OP_LW    = 5'd17,
      OP_SW    = 5'd18,
      OP_BEQ   = 5'd19,
      OP_BNE   = 5'd20,
      OP_BLT   = 5'd21,
      OP_BGE   = 5'd22,
      OP_LUI   = 5'd23,
      OP_AUIPC = 5'd24,
      OP_JAL   = 5'd25,
      OP_JALR  = 5'd26
   } op_type;

   typedef enum logic [FMT_W-1:0] {
      FMT_R = 3'd0,
      FMT_I = 3'd1,
      FMT_S = 3'd2,
      FMT_B = 3'd3,
      FMT_U = 3'd4,
      FMT_J = 3'd5
   } fmt_type;

endpackage

`default_nettype wire

FILE: rtl/core/rvdec_if.sv
// Valid/ready channel interfaces for the decoder: instruction items in,
// decoded items out. Depends on rvdec_pkg for field widths.
`default_nettype none

interface rvdec_req_if;
   import rvdec_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvdec_rsp_if;
   import rvdec_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     legal;
   logic [OP_W-1:0]          op;
   logic [FMT_W-1:0]         fmt;
   logic [REG_W-1:0]         rd_index;
   logic [REG_W-1:0]         rs1_index;
   logic [REG_W-1:0]         rs2_index;
   logic signed [WORD_W-1:0] immediate;

   modport source (output valid, output legal, output op, output fmt, output rd_index,
                   output rs1_index, output rs2_index, output immediate, input ready);
   modport sink   (input valid, input legal, input op, input fmt, input rd_index,
                   input rs1_index, input rs2_index, input immediate, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rv32i_subset_instruction_decoder.sv
// RV32I subset decoder: input register, field decode, result register.
// An item passes the input register, then the result register. Throughput: one item per
// cycle; the only loop is the valid/ready pair of the two registers, so a full
// pipeline keeps streaming while the result side takes items.
// Reset (synchronous, active high) empties both stages; payload is not reset.
// Depends on rvdec_pkg and the rvdec_req_if / rvdec_rsp_if interfaces.
`default_nettype none

module rv32i_subset_instruction_decoder (
   input  wire         clock,
   input  wire         reset,
   rvdec_req_if.sink   req_ch,
   rvdec_rsp_if.source rsp_ch
);
   import rvdec_pkg::*;

   logic              s1_valid_ff;
   logic [WORD_W-1:0] word_ff;
   logic              out_load;
   logic              in_ready;

   logic [6:0] opcode;
   logic [2:0] f3;
   logic [6:0] f7;
   logic [WORD_W-1:0] imm_i, imm_s, imm_b, imm_j, imm_u, imm_sh;

   logic              legal_in;
   op_type            op_in;
   fmt_type           fmt_in;
   logic [WORD_W-1:0] imm_in;

   logic                     rsp_valid_ff;
   logic                     legal_ff;
   logic [OP_W-1:0]          op_ff;
   logic [FMT_W-1:0]         fmt_ff;
   logic [REG_W-1:0]         rd_ff, rs1_ff, rs2_ff;
   logic signed [WORD_W-1:0] imm_ff;

   // Handshake: result register loads when empty or drained
   assign out_load      = !rsp_valid_ff || rsp_ch.ready;
   assign in_ready      = !s1_valid_ff || out_load;
   assign req_ch.ready  = in_ready;

   // Input register: hold the word until the result register takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (in_ready && req_ch.valid) begin
         word_ff <= req_ch.instr_word;
      end
   end

   // Slice fields and assemble every immediate form
   assign opcode = word_ff[6:0];
   assign f3     = word_ff[14:12];
   assign f7     = word_ff[31:25];
   assign imm_i  = {{20{word_ff[31]}}, word_ff[31:20]};
   assign imm_s  = {{20{word_ff[31]}}, word_ff[31:25], word_ff[11:7]};
   assign imm_b  = {{19{word_ff[31]}}, word_ff[31], word_ff[7], word_ff[30:25],
                    word_ff[11:8], 1'b0};
   assign imm_j  = {{11{word_ff[31]}}, word_ff[31], word_ff[19:12], word_ff[20],
                    word_ff[30:21], 1'b0};
   assign imm_u  = {word_ff[31:12], 12'b0};
   assign imm_sh = {{(WORD_W-REG_W){1'b0}}, word_ff[24:20]};

   // Decode; anything unlisted drops to illegal with zeroed op, fmt, immediate
   always_comb begin
      legal_in = 1'b0;
      op_in    = OP_ADD;
      fmt_in   = FMT_R;
      imm_in   = '0;
      unique case (opcode)
         OPC_REG: begin
            if (f7 == F7_ZERO) begin
               legal_in = 1'b1;
               unique case (f3)
                  F3_ADD:  op_in = OP_ADD;
                  F3_SLL:  op_in = OP_SLL;
                  F3_SLT:  op_in = OP_SLT;
                  F3_XOR:  op_in = OP_XOR;
                  F3_SR:   op_in = OP_SRL;
                  F3_OR:   op_in = OP_OR;
                  F3_AND:  op_in = OP_AND;
                  default: legal_in = 1'b0;
               endcase
            end else if (f7 == F7_ALT) begin
               if (f3 == F3_ADD) begin
                  legal_in = 1'b1;
                  op_in    = OP_SUB;
               end else if (f3 == F3_SR) begin
                  legal_in = 1'b1;
                  op_in    = OP_SRA;
               end
            end
         end
         OPC_IMM: begin
            unique case (f3)
               F3_ADD: begin
                  legal_in = 1'b1;
                  op_in    = OP_ADDI;
               end
               F3_SLT: begin
                  legal_in = 1'b1;
                  op_in    = OP_SLTI;
               end
               F3_XOR: begin
                  legal_in = 1'b1;
                  op_in    = OP_XORI;
               end
               F3_OR: begin
                  legal_in = 1'b1;
                  op_in    = OP_ORI;
               end
               F3_AND: begin
                  legal_in = 1'b1;
                  op_in    = OP_ANDI;
               end
               F3_SLL: begin
                  if (f7 == F7_ZERO) begin
                     legal_in = 1'b1;
                     op_in    = OP_SLLI;
                  end
               end
               F3_SR: begin
                  if (f7 == F7_ZERO) begin
                     legal_in = 1'b1;
                     op_in    = OP_SRLI;
                  end else if (f7 == F7_ALT) begin
                     legal_in = 1'b1;
                     op_in    = OP_SRAI;
                  end
               end
               default: legal_in = 1'b0;
            endcase
            fmt_in = FMT_I;
            imm_in = (f3 == F3_SLL || f3 == F3_SR) ? imm_sh : imm_i;
         end
         OPC_LOAD: begin
            legal_in = (f3 == F3_WORD);
            op_in    = OP_LW;
            fmt_in   = FMT_I;
            imm_in   = imm_i;
         end
         OPC_STORE: begin
            legal_in = (f3 == F3_WORD);
            op_in    = OP_SW;
            fmt_in   = FMT_S;
            imm_in   = imm_s;
         end
         OPC_BRANCH: begin
            legal_in = 1'b1;
            fmt_in   = FMT_B;
            imm_in   = imm_b;
            unique case (f3)
               F3_BEQ:  op_in = OP_BEQ;
               F3_BNE:  op_in = OP_BNE;
               F3_BLT:  op_in = OP_BLT;
               F3_BGE:  op_in = OP_BGE;
               default: legal_in = 1'b0;
            endcase
         end
         OPC_LUI: begin
            legal_in = 1'b1;
            op_in    = OP_LUI;
            fmt_in   = FMT_U;
            imm_in   = imm_u;
         end
         OPC_AUIPC: begin
            legal_in = 1'b1;
            op_in    = OP_AUIPC;
            fmt_in   = FMT_U;
            imm_in   = imm_u;
         end
         OPC_JAL: begin
            legal_in = 1'b1;
            op_in    = OP_JAL;
            fmt_in   = FMT_J;
            imm_in   = imm_j;
         end
         // funct3 is don't-care for jalr
         OPC_JALR: begin
            legal_in = 1'b1;
            op_in    = OP_JALR;
            fmt_in   = FMT_I;
            imm_in   = imm_i;
         end
         default: legal_in = 1'b0;
      endcase
      if (!legal_in) begin
         op_in  = OP_ADD;
         fmt_in = FMT_R;
         imm_in = '0;
      end
   end

   // Result register: advance when empty or taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (out_load && s1_valid_ff) begin
         legal_ff <= legal_in;
         op_ff    <= op_in;
         fmt_ff   <= fmt_in;
         rd_ff    <= word_ff[11:7];
         rs1_ff   <= word_ff[19:15];
         rs2_ff   <= word_ff[24:20];
         imm_ff   <= imm_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.legal     = legal_ff;
   assign rsp_ch.op        = op_ff;
   assign rsp_ch.fmt       = fmt_ff;
   assign rsp_ch.rd_index  = rd_ff;
   assign rsp_ch.rs1_index = rs1_ff;
   assign rsp_ch.rs2_index = rs2_ff;
   assign rsp_ch.immediate = imm_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rvdec_checker.sv
// Port-level checks for the RV32I subset decoder, bound to its top level.
// Depends on rvdec_pkg and rv32i_subset_instruction_decoder.
`default_nettype none

module rvdec_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire                                 rsp_legal,
   input wire [rvdec_pkg::OP_W-1:0]           rsp_op,
   input wire [rvdec_pkg::FMT_W-1:0]          rsp_fmt,
   input wire signed [rvdec_pkg::WORD_W-1:0]  rsp_immediate
);
   import rvdec_pkg::*;

   // A stalled item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Illegal words carry zeroed op, format and immediate
   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_legal |-> rsp_op == OP_ADD && rsp_fmt == FMT_R
                                  && rsp_immediate == '0)
      else $error("illegal item with nonzero decode");

   // R-type has no immediate; U-type has clear low twelve bits
   a_imm_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_legal |->
         (rsp_fmt != FMT_R || rsp_immediate == '0) &&
         (rsp_fmt != FMT_U || rsp_immediate[11:0] == 12'b0))
      else $error("immediate shape does not match format");

endmodule

bind rv32i_subset_instruction_decoder rvdec_checker u_rvdec_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_legal     (rsp_ch.legal),
   .rsp_op        (rsp_ch.op),
   .rsp_fmt       (rsp_ch.fmt),
   .rsp_immediate (rsp_ch.immediate)
);

`default_nettype wire
